// ----- hw/rtl/three_tap_median_mean_smoother_unit_defines.svh -----
// Assertion macros shared by the smoother RTL.
`ifndef THREE_TAP_MEDIAN_MEAN_SMOOTHER_UNIT_DEFINES_SVH
`define THREE_TAP_MEDIAN_MEAN_SMOOTHER_UNIT_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define TTMMS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TTMMS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TTMMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/ttmms_pkg.sv -----
// Types, constants and window functions for the three-tap smoother.
package ttmms_pkg;

  localparam int SampleW = 8;
  localparam int SumW    = SampleW + 2;

  // floor(s / 3) == (s * 683) >> 11 for all s <= 765
  localparam logic [SumW-1:0] Div3Mul   = SumW'(683);
  localparam int              Div3Shift = 11;
  localparam int              ProdW     = 2 * SumW;

  // Result queue geometry
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Held sample count codes
  localparam logic [1:0] HeldNone = 2'd0;
  localparam logic [1:0] HeldOne  = 2'd1;
  localparam logic [1:0] HeldTwo  = 2'd2;

  typedef struct packed {
    logic [SampleW-1:0] smoothed;
    logic               result_last;
  } result_t;

  function automatic logic [SampleW-1:0] mid_of_three(
    input logic [SampleW-1:0] a,
    input logic [SampleW-1:0] b,
    input logic [SampleW-1:0] c
  );
    logic [SampleW-1:0] lo;
    logic [SampleW-1:0] hi;
    logic [SampleW-1:0] mid;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      mid = lo;
    end else if (c >= hi) begin
      mid = hi;
    end else begin
      mid = c;
    end
    return mid;
  endfunction

  function automatic logic [SampleW-1:0] mean_of_three(
    input logic [SampleW-1:0] a,
    input logic [SampleW-1:0] b,
    input logic [SampleW-1:0] c
  );
    logic [SumW-1:0]  sum;
    logic [ProdW-1:0] prod;
    sum  = SumW'(a) + SumW'(b) + SumW'(c);
    prod = ProdW'(sum) * ProdW'(Div3Mul);
    return prod[Div3Shift +: SampleW];
  endfunction

  function automatic logic [SampleW-1:0] smooth_window(
    input logic               median,
    input logic [SampleW-1:0] a,
    input logic [SampleW-1:0] b,
    input logic [SampleW-1:0] c
  );
    return median ? mid_of_three(a, b, c) : mean_of_three(a, b, c);
  endfunction

endpackage

// ----- hw/rtl/three_tap_median_mean_smoother_unit.sv -----
// Three-tap median / mean smoother with a four-entry result queue.
// Results are registered into the result queue and are presented from its head.
// Throughput: one sample per cycle while the input is not stalled; the last sample of a
// record with two or more samples yields two results, which drain one per cycle from the
// result queue while the output is not stalled. Input stalls while the queue has fewer than two free entries.
// Synchronous active-high reset: empty window, empty queue, median mode selected.
`include "three_tap_median_mean_smoother_unit_defines.svh"

module three_tap_median_mean_smoother_unit (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             use_median,
  // sample input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ttmms_pkg::SampleW-1:0]    sample,
  input  logic                             sample_last,
  // result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ttmms_pkg::SampleW-1:0]    smoothed,
  output logic                             result_last
);

  // Mode register and window state
  logic                          median_mode;
  logic [ttmms_pkg::SampleW-1:0] older_sample;
  logic [ttmms_pkg::SampleW-1:0] newer_sample;
  logic [1:0]                    held_count;

  // Result queue
  ttmms_pkg::result_t              q_mem [ttmms_pkg::QDepth];
  logic [ttmms_pkg::QPtrW-1:0]     wr_ptr;
  logic [ttmms_pkg::QPtrW-1:0]     rd_ptr;
  logic [ttmms_pkg::QCntW-1:0]     q_count;

  // Next-value logic
  logic                          in_fire;
  logic                          out_fire;
  logic                          push_a;
  logic                          push_b;
  ttmms_pkg::result_t            res_a;
  ttmms_pkg::result_t            res_b;
  logic [ttmms_pkg::SampleW-1:0] older_sample_next;
  logic [ttmms_pkg::SampleW-1:0] newer_sample_next;
  logic [1:0]                    held_count_next;
  logic [ttmms_pkg::QCntW-1:0]   push_num;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_count > ttmms_pkg::QCntW'(ttmms_pkg::QDepth - 2);
  assign in_fire   = in_valid & ~in_stall;
  assign out_valid = q_count != '0;
  assign out_fire  = out_valid & ~out_stall;

  assign smoothed    = q_mem[rd_ptr].smoothed;
  assign result_last = q_mem[rd_ptr].result_last;

  // Window evaluation for the accepted sample
  always_comb begin
    push_a            = 1'b0;
    push_b            = 1'b0;
    res_a.smoothed    = ttmms_pkg::smooth_window(median_mode, older_sample,
                                                 newer_sample, sample);
    res_a.result_last = 1'b0;
    res_b.smoothed    = ttmms_pkg::smooth_window(median_mode, newer_sample,
                                                 sample, sample);
    res_b.result_last = 1'b1;
    older_sample_next = older_sample;
    newer_sample_next = newer_sample;
    held_count_next   = held_count;
    if (in_fire) begin
      if (held_count == ttmms_pkg::HeldNone) begin
        if (sample_last) begin
          // single-sample record passes straight through
          push_a            = 1'b1;
          res_a.smoothed    = sample;
          res_a.result_last = 1'b1;
        end else begin
          // left edge replicated
          older_sample_next = sample;
          newer_sample_next = sample;
          held_count_next   = ttmms_pkg::HeldOne;
        end
      end else begin
        push_a            = 1'b1;
        push_b            = sample_last;
        older_sample_next = newer_sample;
        newer_sample_next = sample;
        held_count_next   = sample_last ? ttmms_pkg::HeldNone : ttmms_pkg::HeldTwo;
      end
    end
    push_num = ttmms_pkg::QCntW'(push_a) + ttmms_pkg::QCntW'(push_b);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      median_mode  <= 1'b1;
      older_sample <= '0;
      newer_sample <= '0;
      held_count   <= ttmms_pkg::HeldNone;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      q_count      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        median_mode <= use_median;
      end
      older_sample <= older_sample_next;
      newer_sample <= newer_sample_next;
      held_count   <= held_count_next;
      wr_ptr       <= wr_ptr + ttmms_pkg::QPtrW'(push_num);
      rd_ptr       <= rd_ptr + ttmms_pkg::QPtrW'(out_fire);
      q_count      <= q_count + push_num - ttmms_pkg::QCntW'(out_fire);
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push_a) begin
      q_mem[wr_ptr] <= res_a;
    end
    if (push_b) begin
      q_mem[wr_ptr + ttmms_pkg::QPtrW'(1)] <= res_b;
    end
  end

  // Checks
  `TTMMS_ASSERT_ALWAYS(a_q_bound, q_count <= ttmms_pkg::QCntW'(ttmms_pkg::QDepth), "result queue overflow")
  `TTMMS_ASSERT_IMPL(a_room_for_two, in_fire, q_count <= ttmms_pkg::QCntW'(ttmms_pkg::QDepth - 2), "sample accepted without room for two results")
  `TTMMS_ASSERT_ALWAYS(a_held_range, held_count != 2'd3, "held count out of range")
  `TTMMS_ASSERT_NEXT(a_last_clears, in_fire && sample_last, held_count == ttmms_pkg::HeldNone, "window not cleared after record end")

endmodule
